@@ rtl/core/nam_pkg.sv @@
// Shared widths and constants of the normalizing audio mixer.
`default_nettype none
package nam_pkg;
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 20;
   localparam int GAIN_W   = 17;
   localparam int PROD_W   = 21;
   localparam int QUOT_W   = 16;
   localparam int FRAME_W  = 8;
   localparam int MCNT_W   = 5;
   localparam int DCNT_W   = 4;

   localparam logic [FRAME_W-1:0]  FRAME_LENGTH = 8'd160;
   localparam logic [GAIN_W-1:0]   GAIN_ONE     = 17'h10000;
   localparam logic [QUOT_W-1:0]   LIMIT_HIGH   = 16'h7FFF;
   localparam logic [QUOT_W-1:0]   LIMIT_LOW    = 16'h8000;
   localparam int                  RECOVER_SHIFT = 5;
   localparam logic [MCNT_W-1:0]   MULT_LAST    = 5'd16;
   localparam logic [DCNT_W-1:0]   DIV_LAST     = 4'd15;
endpackage
`default_nettype wire

@@ rtl/core/nam_if.sv @@
// Handshake channel interfaces for mixer requests and mixed responses.
`default_nettype none
interface nam_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [nam_pkg::SAMPLE_W-1:0] sample;
   logic                                last_source;
   modport source (output valid, sample, last_source, input ready);
   modport sink (input valid, sample, last_source, output ready);
endinterface

interface nam_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [nam_pkg::SAMPLE_W-1:0] mixed_sample;
   modport source (output valid, mixed_sample, input ready);
   modport sink (input valid, mixed_sample, output ready);
endinterface
`default_nettype wire

@@ rtl/core/normalized_audio_mixer.sv @@
// Top level of the normalizing audio mixer with adaptive gain and clipping.
//
//   channel   direction   payload                   transaction
//   req_ch    in          sample, last_source       valid && ready
//   rsp_ch    out         mixed_sample              valid && ready
//
// A source sample without last_source only adds to the running sum. A last-source
// sample runs through the bit-serial multiplier (17 steps), and through the serial
// divider as well when the result clips.
// Reset is synchronous and restores a zero sum, unity gain and frame start.
// The result sits in an output register; a new transaction is taken while
// it waits, and the block stalls only when a second result is ready.
`default_nettype none
module normalized_audio_mixer #(
   parameter logic [nam_pkg::FRAME_W-1:0] FRAME_LENGTH = nam_pkg::FRAME_LENGTH
) (
   input wire logic   clock,
   input wire logic   reset,
   nam_req_if.sink    req_ch,
   nam_rsp_if.source  rsp_ch
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIN  = 4'b1000
   } nam_state_type;

   nam_state_type                     state_ff, state_in;
   logic signed [nam_pkg::SUM_W-1:0]  sum_ff;
   logic [nam_pkg::GAIN_W-1:0]        gain_ff;
   logic [nam_pkg::FRAME_W-1:0]       frame_ff;
   logic                              neg_ff;
   logic                              clip_ff;
   logic                              rsp_valid_ff;
   logic [nam_pkg::SAMPLE_W-1:0]      rsp_data_ff;

   logic                              accept;
   logic signed [nam_pkg::SUM_W:0]    wide_sum;
   logic signed [nam_pkg::SUM_W-1:0]  sat_sum;
   logic [nam_pkg::SUM_W-1:0]         mag;
   logic                              mult_start, mult_done;
   logic [nam_pkg::PROD_W-1:0]        scaled;
   logic                              div_start, div_done;
   logic [nam_pkg::QUOT_W-1:0]        quot;
   logic                              clip_hi, clip_lo;
   logic [nam_pkg::QUOT_W-1:0]        limit;
   logic                              slot_free;
   logic [nam_pkg::GAIN_W-1:0]        gain_sel, gain_rec;
   logic [nam_pkg::GAIN_W-1:0]        gain_gap;
   logic [nam_pkg::FRAME_W-1:0]       frame_next;
   logic [nam_pkg::SAMPLE_W-1:0]      out_value;

   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   // Saturating accumulate of the source samples.
   assign wide_sum = {sum_ff[nam_pkg::SUM_W-1], sum_ff}
                   + {{(nam_pkg::SUM_W+1-nam_pkg::SAMPLE_W){req_ch.sample[nam_pkg::SAMPLE_W-1]}},
                      req_ch.sample};
   always_comb begin
      if (wide_sum[nam_pkg::SUM_W] != wide_sum[nam_pkg::SUM_W-1]) begin
         sat_sum = wide_sum[nam_pkg::SUM_W] ? {1'b1, {(nam_pkg::SUM_W-1){1'b0}}}
                                            : {1'b0, {(nam_pkg::SUM_W-1){1'b1}}};
      end else begin
         sat_sum = wide_sum[nam_pkg::SUM_W-1:0];
      end
   end
   assign mag = sat_sum[nam_pkg::SUM_W-1] ? (~sat_sum + 1'b1) : sat_sum;

   assign mult_start = accept && req_ch.last_source;

   nam_serial_mult u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mult_start),
      .mag     (mag),
      .gain    (gain_ff),
      .done    (mult_done),
      .product (scaled)
   );

   // Clip checks on the magnitude: positive above 32767, negative below -32768.
   assign clip_hi   = !neg_ff && (scaled > {5'b0, nam_pkg::LIMIT_HIGH});
   assign clip_lo   = neg_ff && (scaled > {5'b0, nam_pkg::LIMIT_LOW});
   assign limit     = neg_ff ? nam_pkg::LIMIT_LOW : nam_pkg::LIMIT_HIGH;
   assign div_start = (state_ff == ST_MUL) && mult_done && (clip_hi || clip_lo);

   nam_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (scaled),
      .limit    (limit),
      .done     (div_done),
      .quotient (quot)
   );

   // Final gain: clip gain if any, then recovery toward unity.
   assign gain_sel = clip_ff ? {1'b0, quot} : gain_ff;
   assign gain_gap = nam_pkg::GAIN_ONE - gain_sel;
   assign gain_rec = (gain_sel < nam_pkg::GAIN_ONE)
                   ? gain_sel + (gain_gap >> nam_pkg::RECOVER_SHIFT) : gain_sel;
   assign frame_next = frame_ff + 1'b1;

   always_comb begin
      if (clip_ff) begin
         out_value = neg_ff ? nam_pkg::LIMIT_LOW : nam_pkg::LIMIT_HIGH;
      end else if (neg_ff) begin
         out_value = ~scaled[nam_pkg::SAMPLE_W-1:0] + 1'b1;
      end else begin
         out_value = scaled[nam_pkg::SAMPLE_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (mult_start) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mult_done) begin
               state_in = div_start ? ST_DIV : ST_FIN;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         gain_ff      <= nam_pkg::GAIN_ONE;
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         clip_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            sum_ff <= req_ch.last_source ? '0 : sat_sum;
         end
         if ((state_ff == ST_MUL) && mult_done) begin
            clip_ff <= clip_hi || clip_lo;
         end
         if ((state_ff == ST_FIN) && slot_free) begin
            rsp_valid_ff <= 1'b1;
            if (frame_next >= FRAME_LENGTH) begin
               frame_ff <= '0;
               gain_ff  <= nam_pkg::GAIN_ONE;
            end else begin
               frame_ff <= frame_next;
               gain_ff  <= gain_rec;
            end
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mult_start) begin
         neg_ff <= sat_sum[nam_pkg::SUM_W-1];
      end
      if ((state_ff == ST_FIN) && slot_free) begin
         rsp_data_ff <= out_value;
      end
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.mixed_sample = rsp_data_ff;
endmodule
`default_nettype wire

@@ rtl/core/nam_serial_mult.sv @@
// Bit-serial shift-add multiplier giving magnitude times gain, shifted right by 16.
`default_nettype none
module nam_serial_mult (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [nam_pkg::SUM_W-1:0]     mag,
   input  wire logic [nam_pkg::GAIN_W-1:0]    gain,
   output logic                               done,
   output logic [nam_pkg::PROD_W-1:0]         product
);
   logic                          busy_ff;
   logic                          done_ff;
   logic [nam_pkg::MCNT_W-1:0]    cnt_ff;
   logic [nam_pkg::SUM_W-1:0]     acc_ff;
   logic [nam_pkg::SUM_W-1:0]     mag_ff;
   logic [nam_pkg::GAIN_W-1:0]    gain_sh_ff;
   logic [nam_pkg::PROD_W-1:0]    prod_ff;
   logic [nam_pkg::SUM_W-1:0]     addend;
   logic [nam_pkg::PROD_W-1:0]    sum_in;

   // One gain bit per cycle; each step drops one product bit off the bottom,
   // and the top gain bit is added without a shift.
   assign addend = gain_sh_ff[0] ? mag_ff : '0;
   assign sum_in = {1'b0, acc_ff} + {1'b0, addend};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == nam_pkg::MULT_LAST);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == nam_pkg::MULT_LAST) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff     <= '0;
         mag_ff     <= mag;
         gain_sh_ff <= gain;
      end else if (busy_ff) begin
         if (cnt_ff == nam_pkg::MULT_LAST) begin
            prod_ff <= sum_in;
         end else begin
            acc_ff     <= sum_in[nam_pkg::PROD_W-1:1];
            gain_sh_ff <= gain_sh_ff >> 1;
         end
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;
endmodule
`default_nettype wire

@@ rtl/core/nam_serial_div.sv @@
// Restoring divider, one quotient bit per cycle, for the clip gain.
`default_nettype none
module nam_serial_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [nam_pkg::PROD_W-1:0]    divisor,
   input  wire logic [nam_pkg::QUOT_W-1:0]    limit,
   output logic                               done,
   output logic [nam_pkg::QUOT_W-1:0]         quotient
);
   logic                          busy_ff;
   logic                          done_ff;
   logic [nam_pkg::DCNT_W-1:0]    cnt_ff;
   logic [nam_pkg::PROD_W-1:0]    rem_ff;
   logic [nam_pkg::PROD_W-1:0]    div_ff;
   logic [nam_pkg::QUOT_W-1:0]    quot_ff;
   logic [nam_pkg::PROD_W:0]      trial;
   logic [nam_pkg::PROD_W:0]      diff;
   logic                          fits;

   // The dividend is limit * 65536 and the divisor exceeds limit, so the
   // remainder starts at limit and only the 16 zero bits are shifted in.
   assign trial = {rem_ff, 1'b0};
   assign fits  = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == nam_pkg::DIV_LAST);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == nam_pkg::DIV_LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= {{(nam_pkg::PROD_W-nam_pkg::QUOT_W){1'b0}}, limit};
         div_ff  <= divisor;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[nam_pkg::PROD_W-1:0] : trial[nam_pkg::PROD_W-1:0];
         quot_ff <= {quot_ff[nam_pkg::QUOT_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule
`default_nettype wire

@@ bench/normalized_audio_mixer_tb.sv @@
// Self-checking testbench for the normalizing audio mixer: directed table, then random traffic.
module normalized_audio_mixer_tb;

   localparam int     MAX_SOURCES = 8;
   localparam int     STALL_LIMIT = 2000;
   localparam int     DRAIN_CYCLES = 64;
   localparam longint SUM_HIGH = (longint'(1) << (nam_pkg::SUM_W - 1)) - 1;
   localparam longint SUM_LOW = -(longint'(1) << (nam_pkg::SUM_W - 1));
   localparam longint OUT_HIGH = longint'(nam_pkg::LIMIT_HIGH);
   localparam longint OUT_LOW = -longint'(nam_pkg::LIMIT_LOW);
   localparam longint GAIN_UNITY = longint'(nam_pkg::GAIN_ONE);

   typedef logic signed [nam_pkg::SAMPLE_W-1:0] smp_type;

   typedef enum int {MIX_FULL, MIX_QUIET, MIX_LOUD, MIX_FLOOD} mix_style_type;

   typedef struct packed {
      smp_type    smp;
      logic       last;
      logic [4:0] reps;
      logic       pinned;
      smp_type    pin;
   } mix_row_type;

   // The count repeats the sample; last_source and a typed value belong to the final copy.
   localparam int DIRECTED_N = 14;
   localparam mix_row_type DIRECTED [DIRECTED_N] = '{
      '{16'sh0000, 1'b1, 5'd1, 1'b1, 16'sh0000},
      '{16'sh7FFF, 1'b1, 5'd1, 1'b1, 16'sh7FFF},
      '{16'sh8000, 1'b1, 5'd1, 1'b1, 16'sh8000},
      '{16'sh5555, 1'b0, 5'd1, 1'b0, 16'sh0000},
      '{16'shAAAA, 1'b1, 5'd1, 1'b1, 16'shFFFF},
      '{16'sh7FFF, 1'b0, 5'd1, 1'b0, 16'sh0000},
      '{16'sh0001, 1'b1, 5'd1, 1'b1, 16'sh7FFF},
      '{16'sh8000, 1'b0, 5'd1, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b1, 5'd1, 1'b1, 16'sh8000},
      '{16'sd1000, 1'b1, 5'd1, 1'b0, 16'sh0000},
      '{-16'sd1000, 1'b1, 5'd1, 1'b0, 16'sh0000},
      '{16'sh7FFF, 1'b1, 5'd17, 1'b1, 16'sh7FFF},
      '{16'sh7FFF, 1'b1, 5'd1, 1'b0, 16'sh0000},
      '{16'shFFFF, 1'b1, 5'd1, 1'b0, 16'sh0000}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   nam_req_if req_ch ();
   nam_rsp_if rsp_ch ();

   normalized_audio_mixer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   longint              pending_sum = 0;
   longint              mix_gain = GAIN_UNITY;
   int                  frame_pos = 0;
   int                  mixes_done = 0;

   smp_type             expected_mix [$];
   int                  mismatches = 0;

   logic                pin_flag;
   smp_type             pin_value;
   int                  burst_left = 0;
   int                  items_sent = 0;
   logic                ready_level = 1'b0;
   int                  ready_left = 0;
   int                  idle_cycles = 0;

   function automatic void mix_predict(input smp_type smp,
                                       input logic last,
                                       output bit produced,
                                       output smp_type mixed);
      longint total, mag, scaled, level;
      total = pending_sum + longint'(smp);
      if (total > SUM_HIGH) total = SUM_HIGH;
      else if (total < SUM_LOW) total = SUM_LOW;
      produced = last;
      mixed = '0;
      if (!last) begin
         pending_sum = total;
         return;
      end
      mag = (total < 0) ? -total : total;
      scaled = (mag * mix_gain) >> 16;
      level = (total < 0) ? -scaled : scaled;
      // A clip sets the gain to the limit divided by the scaled level.
      if (level > OUT_HIGH) begin
         mix_gain = (OUT_HIGH << 16) / level;
         level = OUT_HIGH;
      end else if (level < OUT_LOW) begin
         mix_gain = ((-OUT_LOW) << 16) / (-level);
         level = OUT_LOW;
      end
      if (mix_gain < GAIN_UNITY)
         mix_gain = mix_gain + ((GAIN_UNITY - mix_gain) >> nam_pkg::RECOVER_SHIFT);
      mixed = level[nam_pkg::SAMPLE_W-1:0];
      pending_sum = 0;
      mixes_done++;
      frame_pos++;
      if (frame_pos >= int'(nam_pkg::FRAME_LENGTH)) begin
         frame_pos = 0;
         mix_gain = GAIN_UNITY;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   // Sender works in bursts; valid drops only across a gap between bursts.
   task automatic send_sample(input smp_type smp, input logic last,
                              input logic pinned, input smp_type pin);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.sample <= smp;
      req_ch.last_source <= last;
      pin_flag <= pinned;
      pin_value <= pin;
      do
         @(posedge clock);
      while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
      items_sent++;
   endtask

   task automatic send_sample_time(input int sources, input mix_style_type style);
      smp_type smp;
      bit      negative;
      negative = bit'($urandom_range(0, 1));
      for (int k = 0; k < sources; k++) begin
         case (style)
            MIX_QUIET: smp = smp_type'($urandom_range(0, 400) - 200);
            MIX_LOUD, MIX_FLOOD: begin
               smp = negative ? smp_type'(-$urandom_range(16384, 32768))
                              : smp_type'($urandom_range(16384, 32767));
               if (style == MIX_FLOOD && $urandom_range(0, 1) == 0)
                  smp = negative ? 16'sh8000 : 16'sh7FFF;
            end
            default: smp = smp_type'($urandom);
         endcase
         send_sample(smp, k == sources - 1, 1'b0, '0);
      end
   endtask

   // Request monitor: every accepted transaction advances the predictor.
   always @(posedge clock) begin : req_monitor
      bit      produced;
      smp_type mixed;
      if (!reset && req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
         mix_predict(req_ch.sample, req_ch.last_source, produced, mixed);
         if (produced)
            expected_mix = {expected_mix, pin_flag ? pin_value : mixed};
      end
   end

   always @(posedge clock) begin : rsp_monitor
      smp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_mix.size() == 0) begin
            report_mismatch($sformatf("unexpected mixed_sample %0d", rsp_ch.mixed_sample));
         end else begin
            want = expected_mix.pop_front();
            if (rsp_ch.mixed_sample !== want)
               report_mismatch($sformatf("mixed_sample %0d, expected %0d",
                                         rsp_ch.mixed_sample, want));
         end
      end
   end

   // Receiver alternates ready runs and stall runs, with an occasional long open stretch.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_level = !ready_level;
         if (ready_level)
            ready_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
         else
            ready_left = $urandom_range(1, 25);
      end else begin
         ready_left--;
      end
      rsp_ch.ready <= ready_level;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("normalized_audio_mixer regression: fail");
         $finish;
      end
   end

   initial begin
      int            pick;
      mix_style_type style;
      int            sources;
      req_ch.valid <= 1'b0;
      req_ch.sample <= '0;
      req_ch.last_source <= 1'b0;
      pin_flag <= 1'b0;
      pin_value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[r]) begin
         for (int k = 0; k < int'(DIRECTED[r].reps); k++)
            send_sample(DIRECTED[r].smp,
                        DIRECTED[r].last && (k == int'(DIRECTED[r].reps) - 1),
                        DIRECTED[r].pinned && (k == int'(DIRECTED[r].reps) - 1),
                        DIRECTED[r].pin);
      end

      // Run past at least one frame boundary so the gain reset is exercised.
      while (items_sent < 500 || mixes_done < int'(nam_pkg::FRAME_LENGTH) + 5) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            style = MIX_FULL;
            sources = 1;
         end else if (pick < 75) begin
            style = MIX_FULL;
            sources = $urandom_range(2, MAX_SOURCES);
         end else if (pick < 87) begin
            style = MIX_QUIET;
            sources = $urandom_range(1, 4);
         end else if (pick < 96) begin
            style = MIX_LOUD;
            sources = $urandom_range(2, MAX_SOURCES);
         end else begin
            style = MIX_FLOOD;
            sources = $urandom_range(17, 20);
         end
         send_sample_time(sources, style);
      end
      req_ch.valid <= 1'b0;

      while (expected_mix.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_mix.size() == 0)
         $display("normalized_audio_mixer regression: pass");
      else
         $display("normalized_audio_mixer regression: fail");
      $finish;
   end
endmodule

@@ normalized_audio_mixer.f @@
rtl/core/nam_pkg.sv
rtl/core/nam_if.sv
rtl/core/nam_serial_mult.sv
rtl/core/nam_serial_div.sv
rtl/core/normalized_audio_mixer.sv
bench/normalized_audio_mixer_tb.sv
